/* hw/rtl/ldcd_pkg.sv */
// Shared types and character codes for the lamp dimmer command decoder.
`timescale 1ns / 1ps

package ldcd_pkg;

   // Frame delimiters and command characters.
   localparam logic [7:0] CH_HASH  = 8'd35;
   localparam logic [7:0] CH_COLON = 8'd58;
   localparam logic [7:0] CH_F     = 8'h66;  // 'f'
   localparam logic [7:0] CH_QUERY = 8'h3F;  // '?'
   localparam logic [7:0] CH_OPEN  = 8'h4F;  // 'O'
   localparam logic [7:0] CH_CLOSE = 8'h43;  // 'C'
   localparam logic [7:0] CH_LEVEL = 8'h4C;  // 'L'
   localparam logic [7:0] CH_LREP  = 8'h6C;  // 'l'
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // Duty level after reset, in thousandths.
   localparam int unsigned DUTY_RESET = 500;

   typedef enum logic [2:0] {
      REPLY_VERSION = 3'd0,
      REPLY_OPENED  = 3'd1,
      REPLY_CLOSED  = 3'd2,
      REPLY_LEVEL   = 3'd3,
      REPLY_REPORT  = 3'd4,
      REPLY_UNKNOWN = 3'd5
   } reply_kind_type;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_DIM  = 2'd1,
      MODE_FULL = 2'd2
   } lamp_mode_type;

   // Number parser progress.
   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } num_phase_type;

   // One decoded reply, handed from the parser to the result register.
   typedef struct packed {
      logic           valid;
      reply_kind_type kind;
      lamp_mode_type  mode;
      logic [9:0]     duty;
   } ldcd_result_type;

endpackage

/* hw/rtl/ldcd_parser.sv */
// Frame tracker, number parser and command decoder, one character per beat.
`timescale 1ns / 1ps

module ldcd_parser #(
   parameter int MAX_CMD_CHARS = 31,
   parameter int DUTY_LIMIT    = 999
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     beat_valid,
   input  logic [7:0]               beat_byte,
   output ldcd_pkg::ldcd_result_type result
);
   import ldcd_pkg::*;

   localparam int CNT_W  = $clog2(MAX_CMD_CHARS + 1);
   localparam int DLOG   = $clog2(DUTY_LIMIT + 1);
   localparam int DUTY_W = (DLOG > 10) ? DLOG : 10;

   logic              in_frame_ff, in_frame_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        first_ff, first_in;
   logic [7:0]        second_ff, second_in;
   num_phase_type     phase_ff, phase_in;
   logic              neg_ff, neg_in;
   logic [15:0]       value_ff, value_in;
   lamp_mode_type     mode_ff, mode_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;

   logic        is_digit;
   logic        is_space;
   logic [15:0] value_x10;
   logic [15:0] level;
   reply_kind_type kind;

   // Character classes and the times-ten accumulate.
   assign is_digit  = (beat_byte >= CH_ZERO) && (beat_byte <= CH_NINE);
   assign is_space  = (beat_byte == CH_SPACE) ||
                      ((beat_byte >= CH_TAB) && (beat_byte <= CH_CR));
   assign value_x10 = {value_ff[12:0], 3'b000} + {value_ff[14:0], 1'b0};
   assign level     = neg_ff ? (16'd0 - value_ff) : value_ff;

   // Next state of the frame, the number and the lamp.
   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      phase_in    = phase_ff;
      neg_in      = neg_ff;
      value_in    = value_ff;
      mode_in     = mode_ff;
      duty_in     = duty_ff;
      kind        = REPLY_UNKNOWN;
      result      = '0;

      if (beat_valid) begin
         if (beat_byte == CH_COLON) begin
            // A colon always starts a fresh frame.
            in_frame_in = 1'b1;
            count_in    = '0;
            first_in    = '0;
            second_in   = '0;
            phase_in    = PH_SKIP;
            neg_in      = 1'b0;
            value_in    = '0;
         end else if (beat_byte != CH_HASH) begin
            if (in_frame_ff && (count_ff < CNT_W'(MAX_CMD_CHARS))) begin
               count_in = count_ff + 1'b1;
               if (count_ff == '0) begin
                  first_in = beat_byte;
               end else if (count_ff == CNT_W'(1)) begin
                  second_in = beat_byte;
               end else if (phase_ff != PH_DONE) begin
                  // Characters from the third on feed the number.
                  if (is_digit) begin
                     value_in = value_x10 + {12'd0, beat_byte[3:0]};
                     phase_in = PH_DIGITS;
                  end else if (phase_ff == PH_SKIP && is_space) begin
                     phase_in = PH_SKIP;
                  end else if (phase_ff == PH_SKIP &&
                               (beat_byte == CH_PLUS || beat_byte == CH_MINUS)) begin
                     neg_in   = (beat_byte == CH_MINUS);
                     phase_in = PH_SIGN;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
            end
         end else if (in_frame_ff) begin
            // Closing hash of an open frame.
            in_frame_in = 1'b0;
            if (count_ff != '0 && first_ff == CH_F) begin
               unique case (second_ff)
                  CH_QUERY: kind = REPLY_VERSION;
                  CH_OPEN: begin
                     kind    = REPLY_OPENED;
                     mode_in = MODE_DIM;
                  end
                  CH_CLOSE: begin
                     kind    = REPLY_CLOSED;
                     mode_in = MODE_OFF;
                  end
                  CH_LEVEL: begin
                     kind = REPLY_LEVEL;
                     if (level == 16'd0) begin
                        mode_in = MODE_OFF;
                     end else if (level <= 16'(DUTY_LIMIT)) begin
                        mode_in = MODE_DIM;
                        duty_in = DUTY_W'(level);
                     end else begin
                        mode_in = MODE_FULL;
                     end
                  end
                  CH_LREP: kind = REPLY_REPORT;
                  default: kind = REPLY_UNKNOWN;
               endcase
               result.valid = 1'b1;
               result.kind  = kind;
               result.mode  = mode_in;
               result.duty  = duty_in[9:0];
            end
         end
      end
   end

   // Parser and lamp registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         first_ff    <= '0;
         second_ff   <= '0;
         phase_ff    <= PH_SKIP;
         neg_ff      <= 1'b0;
         value_ff    <= '0;
         mode_ff     <= MODE_OFF;
         duty_ff     <= DUTY_W'(DUTY_RESET);
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         first_ff    <= first_in;
         second_ff   <= second_in;
         phase_ff    <= phase_in;
         neg_ff      <= neg_in;
         value_ff    <= value_in;
         mode_ff     <= mode_in;
         duty_ff     <= duty_in;
      end
   end

endmodule

/* hw/rtl/lamp_dimmer_command_decoder.sv */
// A reply is registered in the result register after the closing '#' beat passes the input register.
// Throughput: one character per cycle; a character leaves the input register whenever the
// result register is empty or being drained, and a stalled reply holds both registers.
// Reset (synchronous, active high) closes any frame, clears the parser, sets the lamp
// off with duty 500 and empties both registers.
`timescale 1ns / 1ps

module lamp_dimmer_command_decoder #(
   parameter int MAX_CMD_CHARS = 31,
   parameter int DUTY_LIMIT    = 999
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [2:0] reply_kind, [4:3] lamp_mode, [14:5] duty_level
);
   import ldcd_pkg::*;

   logic            s1_valid_ff, s1_valid_in;
   logic [7:0]      s1_byte_ff;
   logic            out_valid_ff, out_valid_in;
   ldcd_result_type out_ff;
   ldcd_result_type result;
   logic            out_free;
   logic            advance;

   // The input register moves on whenever the result register can take a beat.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   ldcd_parser #(
      .MAX_CMD_CHARS(MAX_CMD_CHARS),
      .DUTY_LIMIT   (DUTY_LIMIT)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .beat_valid(advance),
      .beat_byte (s1_byte_ff),
      .result    (result)
   );

   // Valid flags of both registers.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      if (out_free) begin
         out_valid_in = advance && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_byte_ff <= req_tdata;
      end
      if (advance && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.duty, out_ff.mode, out_ff.kind};

`ifndef SYNTHESIS
   a_rsp_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_valid_ff))
      else $error("reply appeared without a character in the input register");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while both registers are blocked");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_ff.mode != 2'd3))
      else $error("illegal lamp mode in reply");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= REPLY_UNKNOWN))
      else $error("illegal reply kind");
`endif

endmodule
